// ----- src/glp_pkg.sv -----
// ----------------------------------------------------------------------------
// glp_pkg: shared types and constants of the g-code line parser
// character codes, code tables, the line summary record and the status check
// ----------------------------------------------------------------------------
package glp_pkg;

	// number of parameter letters and integer digits kept for a value
	localparam int NUM_LETTERS = 26;
	localparam int LTR_W       = 5;
	localparam int MAX_DIGITS  = 9;
	localparam int ACC_W       = 30;
	localparam int SCALE_W     = 4;
	localparam int MANT_W      = 31;
	localparam int CODE_W      = 10;
	localparam int STATUS_W    = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam longint ACC_MAX = (64'd1 << ACC_W) - 64'd1;

	// largest integer part: ten to the digit count minus one, capped to the accumulator
	function automatic longint mant_limit_f();
		longint p;
		p = 1;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (p <= ACC_MAX + 64'd1) p = p * 10;
		end
		return ((p - 1) > ACC_MAX) ? ACC_MAX : (p - 1);
	endfunction

	localparam logic [ACC_W-1:0]   MANT_LIMIT = ACC_W'(mant_limit_f());
	localparam logic [SCALE_W-1:0] FRAC_CAP   = SCALE_W'(9);
	localparam logic [CODE_W-1:0]  CODE_MAX   = CODE_W'(1023);

	// character codes
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_0        = 8'h30;
	localparam logic [7:0] CH_9        = 8'h39;
	localparam logic [7:0] CH_UA       = 8'h41;
	localparam logic [7:0] CH_UZ       = 8'h5A;
	localparam logic [7:0] CH_LA       = 8'h61;
	localparam logic [7:0] CH_LZ       = 8'h7A;
	localparam logic [7:0] CH_G        = 8'h47;
	localparam logic [7:0] CH_M        = 8'h4D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// letter indexes checked for required axes
	localparam logic [LTR_W-1:0] LTR_I = LTR_W'(8);
	localparam logic [LTR_W-1:0] LTR_J = LTR_W'(9);
	localparam logic [LTR_W-1:0] LTR_X = LTR_W'(23);
	localparam logic [LTR_W-1:0] LTR_Y = LTR_W'(24);
	localparam logic [LTR_W-1:0] LTR_Z = LTR_W'(25);

	// record status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BLANK    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_CODE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNSUP    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

	// g codes with argument rules
	localparam logic [CODE_W-1:0] G_RAPID   = 10'd0;
	localparam logic [CODE_W-1:0] G_LINEAR  = 10'd1;
	localparam logic [CODE_W-1:0] G_ARC_CW  = 10'd2;
	localparam logic [CODE_W-1:0] G_ARC_CCW = 10'd3;
	localparam logic [CODE_W-1:0] G_SET_POS = 10'd92;

	// supported code tables
	localparam int G_CNT = 10;
	localparam int M_CNT = 5;
	localparam logic [CODE_W-1:0] G_CODES [G_CNT] = '{
		10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd21, 10'd28, 10'd90, 10'd91, 10'd92
	};
	localparam logic [CODE_W-1:0] M_CODES [M_CNT] = '{
		10'd0, 10'd1, 10'd2, 10'd30, 10'd112
	};

	// summary of one finished line
	typedef struct packed {
		logic                   started;
		logic                   code_found;
		logic                   code_is_m;
		logic [CODE_W-1:0]      code_value;
		logic [NUM_LETTERS-1:0] present;
	} line_desc_t;

	// one stored parameter value
	typedef struct packed {
		logic               neg;
		logic [ACC_W-1:0]   acc;
		logic [SCALE_W-1:0] scale;
	} param_word_t;

	// write into the parameter store
	typedef struct packed {
		logic             we;
		logic [LTR_W-1:0] addr;
		param_word_t      data;
	} param_wr_t;

	// line check against code tables and required axes
	function automatic logic [STATUS_W-1:0] line_status(line_desc_t d);
		logic g_ok;
		logic m_ok;
		logic has_xyz;
		logic has_xy;
		logic has_ij;
		logic [STATUS_W-1:0] st;
		g_ok = 1'b0;
		m_ok = 1'b0;
		for (int i = 0; i < G_CNT; i++) begin
			if (d.code_value == G_CODES[i]) g_ok = 1'b1;
		end
		for (int i = 0; i < M_CNT; i++) begin
			if (d.code_value == M_CODES[i]) m_ok = 1'b1;
		end
		has_xyz = d.present[LTR_X] | d.present[LTR_Y] | d.present[LTR_Z];
		has_xy  = d.present[LTR_X] | d.present[LTR_Y];
		has_ij  = d.present[LTR_I] | d.present[LTR_J];
		st = ST_OK;
		if (!d.started) begin
			st = ST_BLANK;
		end else if (!d.code_found) begin
			st = ST_NO_CODE;
		end else if (d.code_is_m) begin
			st = m_ok ? ST_OK : ST_UNSUP;
		end else if (!g_ok) begin
			st = ST_UNSUP;
		end else if ((d.code_value == G_RAPID || d.code_value == G_LINEAR ||
				d.code_value == G_SET_POS) && !has_xyz) begin
			st = ST_MISSING;
		end else if ((d.code_value == G_ARC_CW || d.code_value == G_ARC_CCW) &&
				(!has_xy || !has_ij)) begin
			st = ST_MISSING;
		end
		return st;
	endfunction

endpackage

// ----- src/glp_front.sv -----
// ----------------------------------------------------------------------------
// glp_front: character scanner
// tokenizes the line one character a cycle while in_ready is high, keeps the code,
// writes parameter values into the store and hands a line summary to the queue at line end
// ----------------------------------------------------------------------------
module glp_front
	import glp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_ch,
	input  logic        in_line_end,
	input  logic        q_full,
	input  logic        line_done,
	output logic        push,
	output line_desc_t  push_desc,
	output param_wr_t   param_wr
);

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_CODE    = 2'd1;
	localparam logic [1:0] MODE_PARAM   = 2'd2;
	localparam logic [1:0] MODE_COMMENT = 2'd3;

	logic [1:0]             mode_q, mode_n;
	logic                   neg_q, neg_n;
	logic                   dot_q, dot_n;
	logic                   stop_q, stop_n;
	logic                   run_q, run_n;
	logic                   started_q, started_n;
	logic [LTR_W-1:0]       letter_q, letter_n;
	logic [ACC_W-1:0]       acc_q, acc_n;
	logic [SCALE_W-1:0]     scale_q, scale_n;
	logic [NUM_LETTERS-1:0] present_q, present_n;
	logic                   found_q, found_n;
	logic [CODE_W-1:0]      code_q, code_n;
	logic                   is_m_q, is_m_n;
	logic                   busy_q;

	logic             accept;
	logic [7:0]       upc;
	logic             is_digit, is_dot, is_minus, is_space, is_letter;
	logic [3:0]       digit;
	logic [ACC_W+3:0] acc_nv;
	logic [13:0]      code_nv;
	logic [ACC_W-1:0] acc_b;
	logic [SCALE_W-1:0] scale_b;
	logic [CODE_W-1:0]  code_b;

	assign in_ready = !busy_q && !q_full;
	assign accept   = in_valid && in_ready;

	// character classes
	always_comb begin
		is_digit  = (in_ch >= CH_0) && (in_ch <= CH_9);
		is_dot    = (in_ch == CH_DOT);
		is_minus  = (in_ch == CH_MINUS);
		is_space  = (in_ch == CH_SPACE) || ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
		upc       = ((in_ch >= CH_LA) && (in_ch <= CH_LZ)) ? (in_ch - CASE_OFFSET) : in_ch;
		is_letter = (upc >= CH_UA) && (upc <= CH_UZ);
		digit     = 4'(in_ch - CH_0);
	end

	// next scanner state
	always_comb begin
		mode_n    = mode_q;
		neg_n     = neg_q;
		dot_n     = dot_q;
		stop_n    = stop_q;
		run_n     = run_q;
		started_n = started_q;
		letter_n  = letter_q;
		acc_n     = acc_q;
		scale_n   = scale_q;
		present_n = present_q;
		found_n   = found_q;
		code_n    = code_q;
		is_m_n    = is_m_q;
		acc_b     = run_q ? acc_q : '0;
		scale_b   = run_q ? scale_q : '0;
		code_b    = run_q ? code_q : '0;
		acc_nv    = ((ACC_W+4)'(acc_b) << 3) + ((ACC_W+4)'(acc_b) << 1) + (ACC_W+4)'(digit);
		code_nv   = (14'(code_b) << 3) + (14'(code_b) << 1) + 14'(digit);
		param_wr  = '0;
		param_wr.addr = letter_q;

		if (mode_q == MODE_COMMENT) begin
			mode_n = MODE_COMMENT;
		end else if (mode_q == MODE_PARAM && (is_digit || is_dot || is_minus)) begin
			// value run character
			if (!run_q) begin
				present_n[letter_q] = 1'b1;
				neg_n  = 1'b0;
				dot_n  = 1'b0;
				stop_n = 1'b0;
				run_n  = 1'b1;
			end
			acc_n   = acc_b;
			scale_n = scale_b;
			if (!(run_q && stop_q)) begin
				if (is_minus) begin
					if (!run_q) neg_n = 1'b1;
					else stop_n = 1'b1;
				end else if (is_dot) begin
					if (run_q && dot_q) stop_n = 1'b1;
					else dot_n = 1'b1;
				end else if (!(run_q && dot_q)) begin
					if (acc_nv > (ACC_W+4)'(MANT_LIMIT)) begin
						acc_n  = MANT_LIMIT;
						stop_n = 1'b1;
					end else begin
						acc_n = acc_nv[ACC_W-1:0];
					end
				end else if ((scale_b >= FRAC_CAP) || (acc_nv > (ACC_W+4)'(MANT_LIMIT))) begin
					stop_n = 1'b1;
				end else begin
					acc_n   = acc_nv[ACC_W-1:0];
					scale_n = scale_b + 1'b1;
				end
			end
			param_wr.we         = accept;
			param_wr.data.neg   = neg_n;
			param_wr.data.acc   = acc_n;
			param_wr.data.scale = scale_n;
		end else if (mode_q == MODE_CODE && (is_digit || is_dot)) begin
			// code run character
			if (!run_q) begin
				found_n = 1'b1;
				run_n   = 1'b1;
			end
			code_n = code_b;
			if (is_dot) begin
				stop_n = 1'b1;
			end else if (!stop_q) begin
				code_n = (code_nv > 14'(CODE_MAX)) ? CODE_MAX : code_nv[CODE_W-1:0];
			end
		end else if (in_ch == CH_SEMI) begin
			mode_n = MODE_COMMENT;
		end else if (is_space) begin
			mode_n = MODE_IDLE;
		end else begin
			// token start or stray character
			started_n = 1'b1;
			neg_n     = 1'b0;
			dot_n     = 1'b0;
			stop_n    = 1'b0;
			run_n     = 1'b0;
			mode_n    = MODE_IDLE;
			if (is_letter) begin
				if (upc == CH_G || upc == CH_M) begin
					if (!found_q) begin
						mode_n = MODE_CODE;
						is_m_n = (upc == CH_M);
					end
				end else begin
					mode_n   = MODE_PARAM;
					letter_n = LTR_W'(upc - CH_UA);
				end
			end
		end
	end

	// line summary into the queue
	assign push = accept && in_line_end;
	always_comb begin
		push_desc.started    = started_n;
		push_desc.code_found = found_n;
		push_desc.code_is_m  = is_m_n;
		push_desc.code_value = code_n;
		push_desc.present    = present_n;
	end

	// scanner registers, cleared at line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			neg_q     <= 1'b0;
			dot_q     <= 1'b0;
			stop_q    <= 1'b0;
			run_q     <= 1'b0;
			started_q <= 1'b0;
			letter_q  <= '0;
			acc_q     <= '0;
			scale_q   <= '0;
			present_q <= '0;
			found_q   <= 1'b0;
			code_q    <= '0;
			is_m_q    <= 1'b0;
		end else if (accept) begin
			if (in_line_end) begin
				mode_q    <= MODE_IDLE;
				neg_q     <= 1'b0;
				dot_q     <= 1'b0;
				stop_q    <= 1'b0;
				run_q     <= 1'b0;
				started_q <= 1'b0;
				letter_q  <= '0;
				acc_q     <= '0;
				scale_q   <= '0;
				present_q <= '0;
				found_q   <= 1'b0;
				code_q    <= '0;
				is_m_q    <= 1'b0;
			end else begin
				mode_q    <= mode_n;
				neg_q     <= neg_n;
				dot_q     <= dot_n;
				stop_q    <= stop_n;
				run_q     <= run_n;
				started_q <= started_n;
				letter_q  <= letter_n;
				acc_q     <= acc_n;
				scale_q   <= scale_n;
				present_q <= present_n;
				found_q   <= found_n;
				code_q    <= code_n;
				is_m_q    <= is_m_n;
			end
		end
	end

	// hold off the next line until the store has been read out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (push) begin
			busy_q <= 1'b1;
		end else if (line_done) begin
			busy_q <= 1'b0;
		end
	end

endmodule

// ----- src/glp_queue.sv -----
// ----------------------------------------------------------------------------
// glp_queue: line summary queue
// short first-in first-out buffer between the scanner and the record emitter
// ----------------------------------------------------------------------------
module glp_queue
	import glp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  line_desc_t push_desc,
	input  logic       pop,
	output line_desc_t head,
	output logic       empty,
	output logic       full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	line_desc_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_desc;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- src/glp_back.sv -----
// ----------------------------------------------------------------------------
// glp_back: record emitter
// checks each queued line, walks the present letters of an OK line in order, reads the
// parameter store and drives the output register
// ----------------------------------------------------------------------------
module glp_back
	import glp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  param_wr_t           param_wr,
	input  line_desc_t          head,
	input  logic                q_empty,
	output logic                pop,
	output logic                line_done,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic                out_code_kind,
	output logic [CODE_W-1:0]   out_code_number,
	output logic [LTR_W-1:0]    out_letter,
	output logic                out_letter_valid,
	output logic [MANT_W-1:0]   out_mantissa,
	output logic [SCALE_W-1:0]  out_frac_digits,
	output logic                out_last
);

	param_word_t mem_q [NUM_LETTERS];

	// line being emitted
	logic                   emit_q;
	logic                   single_q;
	logic [NUM_LETTERS-1:0] mask_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   kind_q;
	logic [CODE_W-1:0]      num_q;

	// read stage
	logic                s1_valid_q;
	logic [STATUS_W-1:0] status_s1;
	logic                kind_s1;
	logic [CODE_W-1:0]   num_s1;
	logic [LTR_W-1:0]    letter_s1;
	logic                lvalid_s1;
	logic                last_s1;
	param_word_t         rd_s1;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q2;
	logic                kind_q2;
	logic [CODE_W-1:0]   num_q2;
	logic [LTR_W-1:0]    letter_q2;
	logic                lvalid_q2;
	logic [MANT_W-1:0]   mant_q2;
	logic [SCALE_W-1:0]  scale_q2;
	logic                last_q2;

	logic [STATUS_W-1:0]    head_status;
	logic                   head_codes;
	logic                   adv_out;
	logic                   move;
	logic                   issue;
	logic                   issue_last;
	logic [LTR_W-1:0]       pick;
	logic [NUM_LETTERS-1:0] mask_rest;
	logic [MANT_W-1:0]      mag;

	// parameter store
	always_ff @(posedge clk) begin
		if (param_wr.we) mem_q[param_wr.addr] <= param_wr.data;
	end

	// line classification at the queue head
	assign head_status = line_status(head);
	assign head_codes  = (head_status == ST_OK) || (head_status == ST_UNSUP) ||
		(head_status == ST_MISSING);
	assign pop = !emit_q && !q_empty;

	// lowest present letter
	always_comb begin
		pick = '0;
		for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
			if (mask_q[i]) pick = LTR_W'(i);
		end
		mask_rest = mask_q;
		mask_rest[pick] = 1'b0;
	end

	// issue and advance control
	assign adv_out    = !out_valid_q || out_ready;
	assign move       = s1_valid_q && adv_out;
	assign issue      = emit_q && (!s1_valid_q || adv_out);
	assign issue_last = single_q || (mask_rest == '0);
	assign line_done  = issue && issue_last;

	// line registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q   <= 1'b0;
			single_q <= 1'b0;
			mask_q   <= '0;
		end else if (pop) begin
			emit_q   <= 1'b1;
			single_q <= (head_status != ST_OK) || (head.present == '0);
			mask_q   <= (head_status == ST_OK) ? head.present : '0;
		end else if (issue) begin
			mask_q <= mask_rest;
			if (issue_last) emit_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= head_status;
			kind_q   <= head_codes ? head.code_is_m : 1'b0;
			num_q    <= head_codes ? head.code_value : '0;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (issue) begin
			s1_valid_q <= 1'b1;
		end else if (move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1 <= status_q;
			kind_s1   <= kind_q;
			num_s1    <= num_q;
			letter_s1 <= pick;
			lvalid_s1 <= !single_q;
			last_s1   <= issue_last;
			rd_s1     <= mem_q[pick];
		end
	end

	// signed mantissa from the stored magnitude
	always_comb begin
		mag = {1'b0, rd_s1.acc};
		if (rd_s1.neg) mag = MANT_W'(0) - mag;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			status_q2 <= status_s1;
			kind_q2   <= kind_s1;
			num_q2    <= num_s1;
			letter_q2 <= lvalid_s1 ? letter_s1 : '0;
			lvalid_q2 <= lvalid_s1;
			mant_q2   <= lvalid_s1 ? mag : '0;
			scale_q2  <= lvalid_s1 ? rd_s1.scale : '0;
			last_q2   <= last_s1;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_status       = status_q2;
	assign out_code_kind    = kind_q2;
	assign out_code_number  = num_q2;
	assign out_letter       = letter_q2;
	assign out_letter_valid = lvalid_q2;
	assign out_mantissa     = mant_q2;
	assign out_frac_digits  = scale_q2;
	assign out_last         = last_q2;

endmodule

// ----- src/gcode_line_parser_unit.sv -----
// ----------------------------------------------------------------------------
// gcode_line_parser_unit: one character a cycle while a line is scanned; first record
// via queue, line, read and output registers, then one record a cycle while m_tready
// is high; next line accepted once the parameter store has been read for the last record
// asynchronous reset clears control state; the parameter store is not cleared
// ----------------------------------------------------------------------------
module gcode_line_parser_unit
	import glp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [9:0] code_number, [14:10] letter, [45:15] mantissa,
	                               // [49:46] frac_digits, [55:50] zero
	output logic [4:0]  m_tuser,   // [2:0] status, [3] code_kind, [4] letter_valid
	output logic        m_tlast    // last
);

	logic       q_full;
	logic       q_empty;
	logic       push;
	logic       pop;
	logic       line_done;
	line_desc_t push_desc;
	line_desc_t head;
	param_wr_t  param_wr;

	logic [STATUS_W-1:0] status;
	logic                code_kind;
	logic [CODE_W-1:0]   code_number;
	logic [LTR_W-1:0]    letter;
	logic                letter_valid;
	logic [MANT_W-1:0]   mantissa;
	logic [SCALE_W-1:0]  frac_digits;

	// scanner
	glp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_ch       (s_tdata),
		.in_line_end (s_tlast),
		.q_full      (q_full),
		.line_done   (line_done),
		.push        (push),
		.push_desc   (push_desc),
		.param_wr    (param_wr)
	);

	// line summary queue
	glp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// record emitter
	glp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.param_wr         (param_wr),
		.head             (head),
		.q_empty          (q_empty),
		.pop              (pop),
		.line_done        (line_done),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_status       (status),
		.out_code_kind    (code_kind),
		.out_code_number  (code_number),
		.out_letter       (letter),
		.out_letter_valid (letter_valid),
		.out_mantissa     (mantissa),
		.out_frac_digits  (frac_digits),
		.out_last         (m_tlast)
	);

	// output packing
	assign m_tdata = {6'd0, frac_digits, mantissa, letter, code_number};
	assign m_tuser = {letter_valid, code_kind, status};

endmodule
